// ===== rtl/core/utf8d_pkg.sv =====
// Shared types and constants for the lenient UTF-8 decoder.
package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int DUE_W  = 2;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [CP_W-1:0]  partial_point;
    logic [DUE_W-1:0] bytes_due;
  } utf8d_state_t;

  // One decode step's result.
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
    logic            last;
  } utf8d_res_t;

endpackage

// ===== rtl/core/utf8d_step.sv =====
// Combinational decode step: one byte against the current sequence state.
module utf8d_step (
  input  utf8d_pkg::utf8d_state_t       state,
  input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
  input  logic                          block_end,
  output utf8d_pkg::utf8d_state_t       state_next,
  output utf8d_pkg::utf8d_res_t         res
);
  import utf8d_pkg::*;

  logic [CP_W-1:0] shifted;

  assign shifted = {state.partial_point[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    state_next = state;
    res        = '0;
    if (state.bytes_due != '0) begin
      // Any byte counts as a continuation here; low six bits only.
      if (state.bytes_due == DUE_W'(1)) begin
        state_next     = '0;
        res.emit       = 1'b1;
        res.code_point = shifted;
        res.last       = block_end;
      end else if (block_end) begin
        state_next     = '0;
        res.emit       = 1'b1;
        res.code_point = REPLACEMENT;
        res.last       = 1'b1;
      end else begin
        state_next.partial_point = shifted;
        state_next.bytes_due     = state.bytes_due - DUE_W'(1);
      end
    end else begin
      case (data_byte) inside
        [8'h00:8'h7F]: begin
          res.emit       = 1'b1;
          res.code_point = CP_W'(data_byte);
          res.last       = block_end;
        end
        [8'hC0:8'hDF]: begin
          state_next.partial_point = CP_W'(data_byte[4:0]);
          state_next.bytes_due     = DUE_W'(1);
        end
        [8'hE0:8'hEF]: begin
          state_next.partial_point = CP_W'(data_byte[3:0]);
          state_next.bytes_due     = DUE_W'(2);
        end
        [8'hF0:8'hF7]: begin
          state_next.partial_point = CP_W'(data_byte[2:0]);
          state_next.bytes_due     = DUE_W'(3);
        end
        default: begin
          // stray continuation or invalid lead
          res.emit       = 1'b1;
          res.code_point = REPLACEMENT;
          res.last       = block_end;
        end
      endcase
      // lead byte that opens a sequence right at the end of the block
      if (block_end && !res.emit) begin
        state_next     = '0;
        res.emit       = 1'b1;
        res.code_point = REPLACEMENT;
        res.last       = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lenient_utf8_decoder.sv =====
// Top level of the lenient UTF-8 decoder: input register, decode step, result register.
// A byte passes through the input register and then the result register on its way to the output.
// Throughput: one byte per cycle; the single decode step between the input register
//   and the result register sets that figure, and stalls only when a result waits.
// Bytes that leave a sequence open give no output transaction.
// Reset (rst, synchronous, active high) empties both registers and clears the
//   partial code point and the continuation count.
module lenient_utf8_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]  data_byte,
  input  logic                          block_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CP_W-1:0]    code_point,
  output logic                          last_of_block
);
  import utf8d_pkg::*;

  // Input register.
  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_end;

  // Sequence state.
  utf8d_state_t state;
  utf8d_state_t state_next;
  utf8d_res_t   res;

  // The pipeline moves whenever the result register is free or being drained.
  logic advance;
  logic in_take;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  utf8d_step u_step (
    .state      (state),
    .data_byte  (in_byte),
    .block_end  (in_end),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Payload of the input transaction needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= data_byte;
      in_end  <= block_end;
    end
  end

  // State advances only when the held byte is decoded into the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance && in_full) begin
      state <= state_next;
    end
  end

  // Result register: loads a code point, or empties when a byte emits nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full && res.emit) begin
      code_point    <= res.code_point;
      last_of_block <= res.last;
    end
  end

endmodule

// ===== bench/tb_lenient_utf8_decoder.sv =====
// Testbench for lenient_utf8_decoder: byte stimulus, decode prediction and code point checks.
module tb_lenient_utf8_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int N_ITEMS  = 1950;
  localparam int MAX_GAP  = 19;
  localparam int SETTLE   = 8;     // cycles after the last result

  // Tracks the decoder's partial code point and the code points it must emit.
  class decode_tracker;
    typedef struct packed {
      logic [CP_W-1:0] cp;
      logic            last;
    } point_t;

    logic [CP_W-1:0]  part_cp;
    logic [DUE_W-1:0] due;
    point_t           pending_points[$];
    int               mismatches;

    function new();
      part_cp    = '0;
      due        = '0;
      mismatches = 0;
    endfunction

    function void push_point(logic [CP_W-1:0] cp, logic last);
      point_t p;
      p.cp   = cp;
      p.last = last;
      pending_points = {pending_points, p};
    endfunction

    // Called for every byte transaction the decoder accepts.
    function void note_byte(logic [BYTE_W-1:0] b, logic e);
      logic opened;
      opened = 1'b0;
      if (due != 0) begin
        // any byte counts as a continuation, only its low six bits are kept
        part_cp = {part_cp[CP_W-7:0], b[5:0]};
        due     = due - 1'b1;
        if (due == 0) begin
          push_point(part_cp, e);
          part_cp = '0;
        end else if (e) begin
          part_cp = '0;
          due     = '0;
          push_point(REPLACEMENT, 1'b1);
        end
      end else if (!b[7]) begin
        push_point(CP_W'(b), e);
      end else if (b[7:5] == 3'b110) begin
        part_cp = CP_W'(b[4:0]);
        due     = 2'd1;
        opened  = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        part_cp = CP_W'(b[3:0]);
        due     = 2'd2;
        opened  = 1'b1;
      end else if (b[7:3] == 5'b11110) begin
        part_cp = CP_W'(b[2:0]);
        due     = 2'd3;
        opened  = 1'b1;
      end else begin
        push_point(REPLACEMENT, e);
      end
      // lead byte that carries the end mark: truncated
      if (opened && e) begin
        part_cp = '0;
        due     = '0;
        push_point(REPLACEMENT, 1'b1);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Called for every code point transaction the decoder delivers.
    task check_point(logic [CP_W-1:0] cp, logic last);
      point_t p;
      if (pending_points.size() == 0) begin
        report($sformatf("code point %06h with nothing pending", cp));
      end else begin
        p = pending_points.pop_front();
        if (cp !== p.cp)
          report($sformatf("code_point %06h, want %06h", cp, p.cp));
        if (last !== p.last)
          report($sformatf("last_of_block %b, want %b (cp %06h)", last, p.last, p.cp));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte;
  logic                block_end;
  logic                out_valid;
  logic                out_stall;
  logic [CP_W-1:0]     code_point;
  logic                last_of_block;

  decode_tracker tracker = new();

  int bytes_taken  = 0;   // byte transactions seen at the input
  int points_taken = 0;   // code point transactions seen at the output
  int sent         = 0;
  bit calm         = 1'b0; // when set, both sides run without idling

  lenient_utf8_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .last_of_block (last_of_block)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Both channels are sampled at the rising edge. Inputs only move at the
  // falling edge, and the block's outputs still hold their pre-edge values
  // while this block runs, so the sampling is race free.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tracker.note_byte(data_byte, block_end);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        tracker.check_point(code_point, last_of_block);
        points_taken++;
      end
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Any byte value in a continuation slot; mostly the proper 10xxxxxx form.
  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 9) == 0)
      return BYTE_W'($urandom_range(0, 255));
    return 8'h80 | BYTE_W'($urandom_range(0, 63));
  endfunction

  // One byte transaction: optional idle cycles, then hold the byte until taken.
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
    int gap;
    int seen;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    block_end = e;
    seen = bytes_taken;
    do @(negedge clk); while (bytes_taken == seen);
    sent++;
    // switch between idling and back-to-back stretches now and then
    if (sent % 150 == 0)
      calm = ($urandom_range(0, 3) == 0);
  endtask

  // Receiver: stall for a drawn number of cycles, then take one code point.
  initial begin
    int gap;
    int seen;
    out_stall = 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      seen = points_taken;
      do @(negedge clk); while (points_taken == seen);
    end
  end

  // Sender and end of run.
  initial begin
    logic [BYTE_W-1:0] seq[$];
    int pick;
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    block_end = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // overlong two-byte form passes through as U+0000
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // three-byte euro sign
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // surrogate passes through
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // largest four-byte value, completing on the end byte
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // stray bytes at both ends of both stray ranges
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // lead byte with the end mark: truncated
    send_byte(8'hDF, 1'b1);
    // end mark in the middle of a four-byte sequence: truncated
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b1);
    // lead-like values in continuation slots are masked
    send_byte(8'hE1, 1'b0);
    send_byte(8'hF5, 1'b0);
    send_byte(8'hC3, 1'b0);

    // random: mostly well-formed sequences with random content, some noise,
    // end marks dropped anywhere so truncation is hit too
    while (sent < N_ITEMS) begin
      seq.delete();
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          seq = {seq, BYTE_W'($urandom_range(0, 127))};
        end
        3, 4: begin
          seq = {seq, 8'hC0 | BYTE_W'($urandom_range(0, 31))};
          seq = {seq, cont_byte()};
        end
        5, 6: begin
          seq = {seq, 8'hE0 | BYTE_W'($urandom_range(0, 15))};
          repeat (2) seq = {seq, cont_byte()};
        end
        7: begin
          seq = {seq, 8'hF0 | BYTE_W'($urandom_range(0, 7))};
          repeat (3) seq = {seq, cont_byte()};
        end
        default: begin
          seq = {seq, BYTE_W'($urandom_range(0, 255))};
        end
      endcase
      foreach (seq[i])
        send_byte(seq[i], ($urandom_range(0, 15) == 0));
    end
    in_valid = 1'b0;

    while (tracker.pending_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (tracker.mismatches == 0 && tracker.pending_points.size() == 0)
      $display("** lenient_utf8_decoder: PASSED **");
    else
      $display("** lenient_utf8_decoder: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 2 ms).
  initial begin
    #10_000_000;
    $display("** lenient_utf8_decoder: FAILED **");
    $finish;
  end

endmodule
